### rtl/sb2d_pkg.sv
package sb2d_pkg;

    // Conversion geometry
    localparam int VALUE_BITS  = 128;
    localparam int DIGIT_COUNT = 39;
    localparam int DIGIT_W     = 4;
    localparam int BCD_W       = DIGIT_COUNT * DIGIT_W;

    // Stream widths: two 64-bit halves in, one byte-padded digit out
    localparam int IN_W  = 128;
    localparam int OUT_W = 8;

    // Counter widths
    localparam int BIT_CW = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
    localparam int LEFT_W = $clog2(DIGIT_COUNT + 1);

    // Queue between the front and the back
    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    // Add-3 threshold and correction of double dabble
    localparam logic [DIGIT_W-1:0] ADD3_MIN = DIGIT_W'(5);
    localparam logic [DIGIT_W-1:0] ADD3_VAL = DIGIT_W'(3);

    // One classified value on its way to the converter
    typedef struct packed {
        logic                  neg;
        logic [VALUE_BITS-1:0] mag;
    } t_item;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_CONV,
        BK_SCAN,
        BK_EMIT
    } t_bk_state;

    // One double dabble step: adjust each digit, then shift the whole
    // BCD word left by one taking the next magnitude bit at the bottom
    function automatic logic [BCD_W-1:0] dabble_step(input logic [BCD_W-1:0] bcd,
                                                     input logic             bit_in);
        logic [BCD_W-1:0]   adj;
        logic [DIGIT_W-1:0] dig;
        adj = '0;
        for (int d = 0; d < DIGIT_COUNT; d++) begin
            dig = bcd[d*DIGIT_W +: DIGIT_W];
            if (dig >= ADD3_MIN) begin
                dig = dig + ADD3_VAL;
            end
            adj[d*DIGIT_W +: DIGIT_W] = dig;
        end
        return {adj[BCD_W-2:0], bit_in};
    endfunction

endpackage

### rtl/sb2d_front.sv
module sb2d_front
    import sb2d_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_valid,
    output logic            o_cfg_ready,
    input  logic            i_cfg_data,
    input  logic            i_s_axis_tvalid,
    output logic            o_s_axis_tready,
    input  logic [IN_W-1:0] i_s_axis_tdata,
    input  logic            i_full,
    output logic            o_push,
    output t_item           o_item
);

    logic                  r_signed_mode;
    logic [VALUE_BITS-1:0] s_value;
    logic                  s_neg;

    // Hold the mode register; writes are always taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_signed_mode <= 1'b1;
        end else if (i_cfg_valid) begin
            r_signed_mode <= i_cfg_data;
        end
    end

    assign o_cfg_ready = 1'b1;

    // Classify the beat: drop bits above the value width, negate if signed and negative
    assign s_value = i_s_axis_tdata[VALUE_BITS-1:0];
    assign s_neg   = r_signed_mode & s_value[VALUE_BITS-1];

    always_comb begin
        o_item.neg = s_neg;
        o_item.mag = s_neg ? (~s_value + VALUE_BITS'(1)) : s_value;
    end

    assign o_s_axis_tready = !i_full;
    assign o_push          = i_s_axis_tvalid & !i_full;

endmodule

### rtl/sb2d_fifo.sv
module sb2d_fifo
    import sb2d_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_empty,
    output t_item o_item
);

    t_item             r_mem [Q_DEPTH];
    logic [Q_AW-1:0]   r_wr;
    logic [Q_AW-1:0]   r_rd;
    logic [Q_CW-1:0]   r_cnt;
    logic [Q_AW-1:0]   n_wr;
    logic [Q_AW-1:0]   n_rd;

    // Advance pointers with wrap at the queue depth
    assign n_wr = (r_wr == Q_AW'(Q_DEPTH - 1)) ? '0 : r_wr + 1'b1;
    assign n_rd = (r_rd == Q_AW'(Q_DEPTH - 1)) ? '0 : r_rd + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= n_wr;
            end
            if (i_pop) begin
                r_rd <= n_rd;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Store entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    assign o_item  = r_mem[r_rd];
    assign o_full  = (r_cnt == Q_CW'(Q_DEPTH));
    assign o_empty = (r_cnt == '0);

endmodule

### rtl/sb2d_back.sv
module sb2d_back
    import sb2d_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_item              i_item,
    input  logic               i_empty,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [DIGIT_W-1:0] o_digit,
    output logic               o_neg,
    output logic               o_last
);

    t_bk_state             r_state;
    t_bk_state             n_state;
    logic [VALUE_BITS-1:0] r_mag;
    logic                  r_neg;
    logic [BCD_W-1:0]      r_bcd;
    logic [BIT_CW-1:0]     r_bit;
    logic [LEFT_W-1:0]     r_left;
    logic                  r_out_valid;
    logic [DIGIT_W-1:0]    r_out_digit;
    logic                  r_out_neg;
    logic                  r_out_last;

    logic [DIGIT_W-1:0]    s_top;
    logic                  s_top_skip;
    logic                  s_bit_done;
    logic                  s_one_left;
    logic                  s_load;
    logic                  s_conv;
    logic                  s_shift;
    logic                  s_emit;

    assign s_top      = r_bcd[BCD_W-1 -: DIGIT_W];
    assign s_one_left = (r_left == LEFT_W'(1));
    assign s_top_skip = (s_top == '0) && !s_one_left;
    assign s_bit_done = (r_bit == BIT_CW'(VALUE_BITS - 1));

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE: begin
                if (!i_empty) begin
                    n_state = BK_CONV;
                end
            end
            BK_CONV: begin
                if (s_bit_done) begin
                    n_state = BK_SCAN;
                end
            end
            BK_SCAN: begin
                if (!s_top_skip) begin
                    n_state = BK_EMIT;
                end
            end
            BK_EMIT: begin
                if ((!r_out_valid || i_ready) && s_one_left) begin
                    n_state = BK_IDLE;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    // Control outputs per state
    always_comb begin
        s_load  = 1'b0;
        s_conv  = 1'b0;
        s_shift = 1'b0;
        s_emit  = 1'b0;
        case (r_state)
            BK_IDLE: begin
                s_load = !i_empty;
            end
            BK_CONV: begin
                s_conv = 1'b1;
            end
            BK_SCAN: begin
                s_shift = s_top_skip;
            end
            BK_EMIT: begin
                s_emit  = !r_out_valid || i_ready;
                s_shift = !r_out_valid || i_ready;
            end
            default: begin
                s_load = 1'b0;
            end
        endcase
    end

    assign o_pop = s_load;

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (s_conv && s_bit_done) begin
                r_left <= LEFT_W'(DIGIT_COUNT);
            end else if (s_shift) begin
                r_left <= r_left - 1'b1;
            end
            if (s_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Magnitude shifter and BCD accumulator
    always_ff @(posedge i_clk) begin
        if (s_load) begin
            r_mag <= i_item.mag;
            r_neg <= i_item.neg;
            r_bcd <= '0;
            r_bit <= '0;
        end else if (s_conv) begin
            r_bcd <= dabble_step(r_bcd, r_mag[VALUE_BITS-1]);
            r_mag <= r_mag << 1;
            r_bit <= r_bit + 1'b1;
        end else if (s_shift) begin
            r_bcd <= r_bcd << DIGIT_W;
        end
    end

    // Output register: load the top digit when the slot is free
    always_ff @(posedge i_clk) begin
        if (s_emit) begin
            r_out_digit <= s_top;
            r_out_neg   <= r_neg;
            r_out_last  <= s_one_left;
        end
    end

    assign o_valid = r_out_valid;
    assign o_digit = r_out_digit;
    assign o_neg   = r_out_neg;
    assign o_last  = r_out_last;

endmodule

### rtl/signed_binary_to_decimal_128.sv
// Signed 128-bit binary to decimal converter.
//
// Input stream: one beat carries one value, value_low in tdata[63:0] and
// value_high in tdata[127:64]. The front classifies the beat (sign, two's
// complement magnitude) and places it in a two-entry queue; tready is low
// only while that queue is full.
// Output stream: one beat per decimal digit, most significant first, with
// leading zeros dropped (zero gives a single 0). tuser is the negative flag,
// the same on every digit of a value; tlast marks the least significant digit.
// Configuration: i_cfg_data is signed_mode (1 = two's complement), taken on
// any cycle with i_cfg_valid; reset value 1. Change it only while idle.
// Timing: a value leaves the queue, passes through the bit-serial double
// dabble shifter, then the leading zero digits are skipped, the first
// digit is found and the digits are emitted one by one. The single shared
// shifter converts one value at a time and takes the next from the queue
// only after the last digit of the current value has been emitted.
// Reset (synchronous, active low) empties the queue and the output register.
// When the receiver stalls the current digit is held in the output register
// and the converter waits; the front keeps taking values until the queue fills.
module signed_binary_to_decimal_128
    import sb2d_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic             i_cfg_data,
    input  logic             i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  logic [IN_W-1:0]  i_s_axis_tdata,   // value_low[63:0], value_high[127:64]
    output logic             o_m_axis_tvalid,
    input  logic             i_m_axis_tready,
    output logic [OUT_W-1:0] o_m_axis_tdata,   // digit[3:0], zero padding [7:4]
    output logic             o_m_axis_tuser,   // negative
    output logic             o_m_axis_tlast    // last_digit
);

    logic               s_push;
    logic               s_pop;
    logic               s_full;
    logic               s_empty;
    t_item              s_in_item;
    t_item              s_q_item;
    logic [DIGIT_W-1:0] s_digit;

    sb2d_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_full          (s_full),
        .o_push          (s_push),
        .o_item          (s_in_item)
    );

    sb2d_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_push),
        .i_item  (s_in_item),
        .o_full  (s_full),
        .i_pop   (s_pop),
        .o_empty (s_empty),
        .o_item  (s_q_item)
    );

    sb2d_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (s_q_item),
        .i_empty (s_empty),
        .o_pop   (s_pop),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_digit (s_digit),
        .o_neg   (o_m_axis_tuser),
        .o_last  (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {(OUT_W - DIGIT_W)'(0), s_digit};

endmodule

### rtl/sb2d_chk.sv
module sb2d_chk
    import sb2d_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             o_m_axis_tvalid,
    input  logic             i_m_axis_tready,
    input  logic [OUT_W-1:0] o_m_axis_tdata,
    input  logic             o_m_axis_tuser,
    input  logic             o_m_axis_tlast
);

    logic r_first;

    // Track whether the next output beat opens a new number
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first <= 1'b1;
        end else if (o_m_axis_tvalid && i_m_axis_tready) begin
            r_first <= o_m_axis_tlast;
        end
    end

    // Output is empty after reset
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid right after reset");

    // A stalled beat holds its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)
            && $stable(o_m_axis_tlast))
        else $error("stalled output beat changed");

    // Every digit is decimal and the padding is zero
    a_decimal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[DIGIT_W-1:0] <= DIGIT_W'(9)
            && o_m_axis_tdata[OUT_W-1:DIGIT_W] == '0)
        else $error("digit out of decimal range");

    // No leading zero on a number of more than one digit
    a_no_lead_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && r_first && !o_m_axis_tlast |->
            o_m_axis_tdata[DIGIT_W-1:0] != '0)
        else $error("leading zero digit emitted");

endmodule

bind signed_binary_to_decimal_128 sb2d_chk u_sb2d_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser),
    .o_m_axis_tlast  (o_m_axis_tlast)
);
